// ===== rtl/assert_macros.svh =====
// assertion macros shared by the limiter rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define CRL_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define CRL_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/crl_pkg.sv =====
// shared types, widths and codes of the client failure rate limiter
package crl_pkg;

    localparam int CLIENTS_DEF = 64;

    localparam int OP_W       = 2;
    localparam int ID_W       = 64;
    localparam int TIME_W     = 48;
    localparam int WL_W       = 32;
    localparam int FAIL_W     = 16;
    localparam int LIVE_W     = 7;
    localparam int CFG_IDX_W  = 8;
    localparam int CFG_DATA_W = 32;

    localparam logic [WL_W-1:0]   WL_RESET   = 32'd60000;
    localparam logic [FAIL_W-1:0] MAXF_RESET = 16'd5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_LENGTH = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_FAILURES  = 8'd1;

    // request operations
    typedef enum logic [OP_W-1:0] {
        OP_CHECK  = 2'd0,
        OP_RECORD = 2'd1,
        OP_RESET  = 2'd2,
        OP_CLEAR  = 2'd3
    } crl_op_t;

    // sequencer states
    typedef enum logic [4:0] {
        ST_INIT   = 5'b00001,
        ST_IDLE   = 5'b00010,
        ST_SCAN   = 5'b00100,
        ST_WIPE   = 5'b01000,
        ST_UPDATE = 5'b10000
    } crl_state_t;

    // sequencer to scan unit
    typedef struct packed {
        logic clr;
        logic issue;
        logic last;
    } crl_scan_ctl_t;

    // scan unit to sequencer
    typedef struct packed {
        logic done;
        logic match_found;
        logic free_found;
    } crl_scan_sts_t;

endpackage

// ===== rtl/crl_ifs.sv =====
// request, result and configuration channel interfaces
interface crl_req_if import crl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   operation;
    logic [ID_W-1:0]   client_id;
    logic [TIME_W-1:0] now_time;

    modport source (output valid, operation, client_id, now_time, input ready);
    modport sink   (input valid, operation, client_id, now_time, output ready);
endinterface

interface crl_rsp_if import crl_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              limited;
    logic              allowed;
    logic [FAIL_W-1:0] failure_count;
    logic [LIVE_W-1:0] live_entries;

    modport source (output valid, limited, allowed, failure_count, live_entries,
                    input ready);
    modport sink   (input valid, limited, allowed, failure_count, live_entries,
                    output ready);
endinterface

interface crl_cfg_if import crl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/crl_store.sv =====
// client table storage: valid bit memory and entry data memory
module crl_store
    import crl_pkg::*;
#(
    parameter int CLIENTS = CLIENTS_DEF,
    parameter int IDX_W   = $clog2(CLIENTS)
)
(
    input  logic              clk,
    // registered read port
    input  logic              rd_en,
    input  logic [IDX_W-1:0]  rd_addr,
    output logic              rd_valid,
    output logic [ID_W-1:0]   rd_client,
    output logic [TIME_W-1:0] rd_start,
    output logic [FAIL_W-1:0] rd_fail,
    // valid bit write port
    input  logic              vwe,
    input  logic [IDX_W-1:0]  vaddr,
    input  logic              vwdata,
    // entry data write port
    input  logic              dwe,
    input  logic [IDX_W-1:0]  daddr,
    input  logic [ID_W-1:0]   dclient,
    input  logic [TIME_W-1:0] dstart,
    input  logic [FAIL_W-1:0] dfail
);

    logic              vld_mem    [CLIENTS];
    logic [ID_W-1:0]   client_mem [CLIENTS];
    logic [TIME_W-1:0] start_mem  [CLIENTS];
    logic [FAIL_W-1:0] fail_mem   [CLIENTS];

    // valid bit memory
    always_ff @(posedge clk)
    begin
        if (vwe)
        begin
            vld_mem[vaddr] <= vwdata;
        end
        if (rd_en)
        begin
            rd_valid <= vld_mem[rd_addr];
        end
    end

    // entry data memory
    always_ff @(posedge clk)
    begin
        if (dwe)
        begin
            client_mem[daddr] <= dclient;
            start_mem[daddr]  <= dstart;
            fail_mem[daddr]   <= dfail;
        end
        if (rd_en)
        begin
            rd_client <= client_mem[rd_addr];
            rd_start  <= start_mem[rd_addr];
            rd_fail   <= fail_mem[rd_addr];
        end
    end

endmodule

// ===== rtl/crl_scan.sv =====
// shared scan unit: expiry and match compare, free, oldest and live tracking
module crl_scan
    import crl_pkg::*;
#(
    parameter int CLIENTS = CLIENTS_DEF,
    parameter int IDX_W   = $clog2(CLIENTS),
    parameter int CNT_W   = $clog2(CLIENTS + 1)
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  crl_scan_ctl_t     ctl,
    input  logic [IDX_W-1:0]  issue_idx,
    // entry read data, arriving in the cycle after issue
    input  logic              ent_valid,
    input  logic [ID_W-1:0]   ent_client,
    input  logic [TIME_W-1:0] ent_start,
    input  logic [FAIL_W-1:0] ent_fail,
    // item key
    input  logic [ID_W-1:0]   key_id,
    input  logic [TIME_W-1:0] key_now,
    input  logic [WL_W-1:0]   key_wl,
    // results
    output crl_scan_sts_t     sts,
    output logic [IDX_W-1:0]  match_idx,
    output logic [FAIL_W-1:0] match_fail,
    output logic [TIME_W-1:0] match_start,
    output logic [IDX_W-1:0]  free_idx,
    output logic [IDX_W-1:0]  oldest_idx,
    output logic [CNT_W-1:0]  live_cnt,
    output logic              drop_we,
    output logic [IDX_W-1:0]  drop_idx
);

    // issue info aligned with the read data
    logic             s0_vld_reg;
    logic             s0_last_reg;
    logic [IDX_W-1:0] s0_idx_reg;

    // compare stage
    logic              sa_vld_reg;
    logic              sa_last_reg;
    logic [IDX_W-1:0]  sa_idx_reg;
    logic              sa_live_reg;
    logic              sa_drop_reg;
    logic              sa_free_reg;
    logic              sa_match_reg;
    logic [TIME_W-1:0] sa_start_reg;
    logic [FAIL_W-1:0] sa_fail_reg;

    // trackers
    logic              done_reg;
    logic              match_found_reg;
    logic [IDX_W-1:0]  match_idx_reg;
    logic [FAIL_W-1:0] match_fail_reg;
    logic [TIME_W-1:0] match_start_reg;
    logic              free_found_reg;
    logic [IDX_W-1:0]  free_idx_reg;
    logic              old_any_reg;
    logic [IDX_W-1:0]  old_idx_reg;
    logic [TIME_W-1:0] old_start_reg;
    logic [CNT_W-1:0]  live_cnt_reg;

    logic [TIME_W:0]   age_diff;
    logic              expired;
    logic              ent_live;

    // window age against window length, backwards time counts as age zero
    always_comb
    begin
        age_diff = {1'b0, key_now} - {1'b0, ent_start};
        if (age_diff[TIME_W])
        begin
            expired = (key_wl == '0);
        end
        else
        begin
            expired = (age_diff[TIME_W-1:0] >= TIME_W'(key_wl));
        end
        ent_live = ent_valid && !expired;
    end

    // issue alignment and compare stage control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_vld_reg <= 1'b0;
            sa_vld_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s0_vld_reg <= ctl.issue;
            sa_vld_reg <= s0_vld_reg;
            done_reg   <= sa_vld_reg && sa_last_reg;
        end
    end

    // compare stage payload
    always_ff @(posedge clk)
    begin
        s0_last_reg  <= ctl.last;
        s0_idx_reg   <= issue_idx;
        sa_last_reg  <= s0_last_reg;
        sa_idx_reg   <= s0_idx_reg;
        sa_live_reg  <= ent_live;
        sa_drop_reg  <= ent_valid && expired;
        sa_free_reg  <= !ent_live;
        sa_match_reg <= ent_live && (ent_client == key_id);
        sa_start_reg <= ent_start;
        sa_fail_reg  <= ent_fail;
    end

    // tracker flags and live count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            old_any_reg     <= 1'b0;
            live_cnt_reg    <= '0;
        end
        else if (ctl.clr)
        begin
            match_found_reg <= 1'b0;
            free_found_reg  <= 1'b0;
            old_any_reg     <= 1'b0;
            live_cnt_reg    <= '0;
        end
        else if (sa_vld_reg)
        begin
            if (sa_match_reg)
            begin
                match_found_reg <= 1'b1;
            end
            if (sa_free_reg)
            begin
                free_found_reg <= 1'b1;
            end
            if (sa_live_reg)
            begin
                old_any_reg  <= 1'b1;
                live_cnt_reg <= live_cnt_reg + CNT_W'(1);
            end
        end
    end

    // tracker payload, first hit wins, oldest keeps the lowest index on a tie
    always_ff @(posedge clk)
    begin
        if (sa_vld_reg)
        begin
            if (sa_match_reg && !match_found_reg)
            begin
                match_idx_reg   <= sa_idx_reg;
                match_fail_reg  <= sa_fail_reg;
                match_start_reg <= sa_start_reg;
            end
            if (sa_free_reg && !free_found_reg)
            begin
                free_idx_reg <= sa_idx_reg;
            end
            if (sa_live_reg && (!old_any_reg || (sa_start_reg < old_start_reg)))
            begin
                old_idx_reg   <= sa_idx_reg;
                old_start_reg <= sa_start_reg;
            end
        end
    end

    assign sts.done        = done_reg;
    assign sts.match_found = match_found_reg;
    assign sts.free_found  = free_found_reg;
    assign match_idx       = match_idx_reg;
    assign match_fail      = match_fail_reg;
    assign match_start     = match_start_reg;
    assign free_idx        = free_idx_reg;
    assign oldest_idx      = old_idx_reg;
    assign live_cnt        = live_cnt_reg;
    assign drop_we         = sa_vld_reg && sa_drop_reg;
    assign drop_idx        = sa_idx_reg;

endmodule

// ===== rtl/client_failure_rate_limiter_core.sv =====
// Per-client fixed-window failure limiter over a table of CLIENTS entries.
// check, record_failure and reset_client run a one-entry-per-cycle table scan;
// clear_all runs a wipe pass over the valid memory instead.
// One request is handled at a time: req.ready is high only in idle.
// Reset: rst_n clears control at once, then a clearing pass runs over the
// valid memory with req.ready low; configuration writes are taken throughout.
`include "assert_macros.svh"

module client_failure_rate_limiter_core
    import crl_pkg::*;
#(
    parameter int CLIENTS = CLIENTS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    crl_req_if.sink   req,
    crl_rsp_if.source rsp,
    crl_cfg_if.sink   cfg
);

    localparam int IDX_W = $clog2(CLIENTS);
    localparam int CNT_W = $clog2(CLIENTS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CLIENTS - 1);

    crl_state_t        state_reg, state_next;
    logic [IDX_W-1:0]  cnt_reg, cnt_next;
    logic              scan_issue_reg, scan_issue_next;

    logic [WL_W-1:0]   window_length_reg;
    logic [FAIL_W-1:0] max_failures_reg;

    crl_op_t           op_reg;
    logic [ID_W-1:0]   id_reg;
    logic [TIME_W-1:0] now_reg;

    logic              rsp_valid_reg;
    logic              limited_reg;
    logic              allowed_reg;
    logic [FAIL_W-1:0] count_reg;
    logic [LIVE_W-1:0] live_reg;

    logic              req_accept;
    logic              out_free;
    logic              load;
    logic              rd_en;
    logic              vwe;
    logic [IDX_W-1:0]  vaddr;
    logic              vwdata;
    logic              dwe;
    crl_scan_ctl_t     sctl;
    crl_scan_sts_t     sts;

    logic              ent_valid;
    logic [ID_W-1:0]   ent_client;
    logic [TIME_W-1:0] ent_start;
    logic [FAIL_W-1:0] ent_fail;

    logic [IDX_W-1:0]  match_idx;
    logic [FAIL_W-1:0] match_fail;
    logic [TIME_W-1:0] match_start;
    logic [IDX_W-1:0]  free_idx;
    logic [IDX_W-1:0]  oldest_idx;
    logic [CNT_W-1:0]  live_cnt;
    logic              drop_we;
    logic [IDX_W-1:0]  drop_idx;

    logic [FAIL_W-1:0] limit;
    logic [FAIL_W-1:0] base_fail;
    logic [TIME_W-1:0] base_start;
    logic              rec_ok;
    logic [FAIL_W-1:0] rec_fail;
    logic [IDX_W-1:0]  target;
    logic              new_live;
    logic              res_limited;
    logic              res_allowed;
    logic [FAIL_W-1:0] res_count;
    logic [CNT_W-1:0]  res_live;

    assign req_accept = req.valid && req.ready;
    assign out_free   = !rsp_valid_reg || rsp.ready;
    assign req.ready  = (state_reg == ST_IDLE);
    assign cfg.ready  = 1'b1;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_length_reg <= WL_RESET;
            max_failures_reg  <= MAXF_RESET;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                CFG_WINDOW_LENGTH: window_length_reg <= cfg.data;
                CFG_MAX_FAILURES:  max_failures_reg  <= cfg.data[FAIL_W-1:0];
                default:           ;
            endcase
        end
    end

    // request capture
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            op_reg  <= crl_op_t'(req.operation);
            id_reg  <= req.client_id;
            now_reg <= req.now_time;
        end
    end

    // result of the finished scan
    always_comb
    begin
        limit       = (max_failures_reg == '0) ? FAIL_W'(1) : max_failures_reg;
        base_fail   = sts.match_found ? match_fail : '0;
        base_start  = sts.match_found ? match_start : now_reg;
        rec_ok      = (base_fail < limit);
        rec_fail    = rec_ok ? base_fail + FAIL_W'(1) : base_fail;
        target      = sts.match_found ? match_idx : (sts.free_found ? free_idx : oldest_idx);
        new_live    = !sts.match_found && sts.free_found && (window_length_reg != '0);
        res_limited = 1'b0;
        res_allowed = 1'b0;
        res_count   = '0;
        res_live    = live_cnt;
        unique case (op_reg)
            OP_CHECK:
            begin
                res_limited = sts.match_found && (match_fail >= limit);
                res_count   = base_fail;
            end
            OP_RECORD:
            begin
                res_allowed = rec_ok;
                res_count   = rec_fail;
                res_live    = live_cnt + CNT_W'(new_live);
            end
            OP_RESET:
            begin
                res_live = live_cnt - CNT_W'(sts.match_found);
            end
            OP_CLEAR:
            begin
                res_live = '0;
            end
            default:
            begin
                res_live = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        scan_issue_next = scan_issue_reg;
        rd_en           = 1'b0;
        sctl            = '0;
        vwe             = 1'b0;
        vaddr           = cnt_reg;
        vwdata          = 1'b0;
        dwe             = 1'b0;
        load            = 1'b0;
        unique case (state_reg)
            ST_INIT:
            begin
                vwe      = 1'b1;
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (req.valid)
                begin
                    cnt_next = '0;
                    if (crl_op_t'(req.operation) == OP_CLEAR)
                    begin
                        state_next = ST_WIPE;
                    end
                    else
                    begin
                        state_next      = ST_SCAN;
                        scan_issue_next = 1'b1;
                        sctl.clr        = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_issue_reg)
                begin
                    rd_en      = 1'b1;
                    sctl.issue = 1'b1;
                    sctl.last  = (cnt_reg == LAST_IDX);
                    cnt_next   = cnt_reg + IDX_W'(1);
                    if (cnt_reg == LAST_IDX)
                    begin
                        cnt_next        = '0;
                        scan_issue_next = 1'b0;
                    end
                end
                // expired entries are dropped as the scan passes them
                if (drop_we)
                begin
                    vwe   = 1'b1;
                    vaddr = drop_idx;
                end
                if (sts.done)
                begin
                    state_next = ST_UPDATE;
                end
            end
            ST_WIPE:
            begin
                vwe      = 1'b1;
                cnt_next = cnt_reg + IDX_W'(1);
                if (cnt_reg == LAST_IDX)
                begin
                    cnt_next   = '0;
                    state_next = ST_UPDATE;
                end
            end
            ST_UPDATE:
            begin
                if (out_free)
                begin
                    load       = 1'b1;
                    state_next = ST_IDLE;
                    if (op_reg == OP_RECORD)
                    begin
                        vwe    = 1'b1;
                        vaddr  = target;
                        vwdata = 1'b1;
                        dwe    = 1'b1;
                    end
                    else if ((op_reg == OP_RESET) && sts.match_found)
                    begin
                        vwe   = 1'b1;
                        vaddr = match_idx;
                    end
                end
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    // sequencer registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_INIT;
            cnt_reg        <= '0;
            scan_issue_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            cnt_reg        <= cnt_next;
            scan_issue_reg <= scan_issue_next;
        end
    end

    // output register control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else if (load)
        begin
            rsp_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_valid_reg <= 1'b0;
        end
    end

    // output register payload
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            limited_reg <= res_limited;
            allowed_reg <= res_allowed;
            count_reg   <= res_count;
            live_reg    <= LIVE_W'(res_live);
        end
    end

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.limited       = limited_reg;
    assign rsp.allowed       = allowed_reg;
    assign rsp.failure_count = count_reg;
    assign rsp.live_entries  = live_reg;

    // client table
    crl_store #(
        .CLIENTS (CLIENTS),
        .IDX_W   (IDX_W)
    ) u_store (
        .clk       (clk),
        .rd_en     (rd_en),
        .rd_addr   (cnt_reg),
        .rd_valid  (ent_valid),
        .rd_client (ent_client),
        .rd_start  (ent_start),
        .rd_fail   (ent_fail),
        .vwe       (vwe),
        .vaddr     (vaddr),
        .vwdata    (vwdata),
        .dwe       (dwe),
        .daddr     (target),
        .dclient   (id_reg),
        .dstart    (base_start),
        .dfail     (rec_fail)
    );

    // shared scan unit
    crl_scan #(
        .CLIENTS (CLIENTS),
        .IDX_W   (IDX_W),
        .CNT_W   (CNT_W)
    ) u_scan (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (sctl),
        .issue_idx   (cnt_reg),
        .ent_valid   (ent_valid),
        .ent_client  (ent_client),
        .ent_start   (ent_start),
        .ent_fail    (ent_fail),
        .key_id      (id_reg),
        .key_now     (now_reg),
        .key_wl      (window_length_reg),
        .sts         (sts),
        .match_idx   (match_idx),
        .match_fail  (match_fail),
        .match_start (match_start),
        .free_idx    (free_idx),
        .oldest_idx  (oldest_idx),
        .live_cnt    (live_cnt),
        .drop_we     (drop_we),
        .drop_idx    (drop_idx)
    );

    // scan completion and drop writes belong to the scan phase
    `CRL_ASSERT_IMP(a_done_in_scan, sts.done, (state_reg == ST_SCAN) && !scan_issue_reg, "scan done outside scan phase")
    `CRL_ASSERT_IMP(a_drop_in_scan, drop_we, state_reg == ST_SCAN, "expiry drop outside scan phase")
    // an entry data write always sets the valid bit of the same entry
    `CRL_ASSERT_IMP(a_data_with_valid, dwe, vwe && vwdata && (vaddr == target), "entry written without valid bit")
    // a finished update always presents a result and returns to idle
    `CRL_ASSERT_NXT(a_update_result, (state_reg == ST_UPDATE) && out_free, rsp_valid_reg && (state_reg == ST_IDLE), "update did not produce a result")

endmodule
